[design/gpw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_pkg
// Shared types, display command codes and the 6x8 font table for the
// glyph page writer.
// ----------------------------------------------------------------------------
package gpw_pkg;

    // Display command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] COL_LOW_MASK  = 8'h0F;

    // Position limits
    localparam logic [7:0] COL_LAST  = 8'd122;
    localparam logic [7:0] PAGE_LAST = 8'd7;

    // Font layout
    localparam logic [7:0] FONT_FIRST  = 8'd32;
    localparam int         ROM_GLYPHS  = 92;
    localparam int         ROM_COLS    = 6;
    localparam int         GLYPH_IDX_W = $clog2(ROM_GLYPHS);
    localparam int         COL_IDX_W   = 3;

    // Byte slots of the header in front of the glyph columns
    localparam int HDR_BYTES    = 3;
    localparam int IDX_PAGE_CMD = 0;
    localparam int IDX_COL_HI   = 1;
    localparam int IDX_COL_LO   = 2;

    // Font read request toward the glyph memory
    typedef struct packed {
        logic                   en;
        logic                   hit;
        logic [GLYPH_IDX_W-1:0] glyph;
        logic [COL_IDX_W-1:0]   col;
    } t_gpw_rd_req;

    // Per-byte control that travels alongside the font read
    typedef struct packed {
        logic [7:0] cmd;
        logic       is_data;
        logic       last;
    } t_gpw_slot;

    localparam logic [7:0] FONT_ROM [ROM_GLYPHS][ROM_COLS] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h00,8'h2F,8'h00,8'h00},
        '{8'h00,8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h00,8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h00,8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h00,8'h62,8'h64,8'h08,8'h13,8'h23},
        '{8'h00,8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h00,8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h00,8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h00,8'h00,8'hA0,8'h60,8'h00}, '{8'h00,8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h00,8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h00,8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h00,8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h00,8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h00,8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h00,8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h00,8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h00,8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h00,8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h00,8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h00,8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h00,8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h00,8'h32,8'h49,8'h59,8'h51,8'h3E}, '{8'h00,8'h7C,8'h12,8'h11,8'h12,8'h7C},
        '{8'h00,8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h00,8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h00,8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h00,8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h00,8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h00,8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h00,8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h00,8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h00,8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h00,8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h00,8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h00,8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h00,8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h00,8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h00,8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h00,8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h00,8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h00,8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h00,8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h00,8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h00,8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h00,8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h00,8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h00,8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h00,8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h00,8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h00,8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h00,8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h00,8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h00,8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h00,8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h00,8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h00,8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h00,8'h18,8'hA4,8'hA4,8'hA4,8'h7C},
        '{8'h00,8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h00,8'h40,8'h80,8'h84,8'h7D,8'h00}, '{8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h00,8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h00,8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h00,8'hFC,8'h24,8'h24,8'h24,8'h18}, '{8'h00,8'h18,8'h24,8'h24,8'h18,8'hFC},
        '{8'h00,8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h00,8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h00,8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h00,8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h00,8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h00,8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h00,8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h00,8'h1C,8'hA0,8'hA0,8'hA0,8'h7C},
        '{8'h00,8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h14}
    };

endpackage

[design/glyph_6x8_page_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_6x8_page_writer_top
// Renders one character as a page-display byte stream: page command, column
// commands, then the glyph columns from the font memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word per character:
//   code, start column and page. A column past 122 restarts at 0 on the next
//   page; a page past 7 becomes 0.
//   Output channel (o_out_valid / i_out_ready) returns 3 + GLYPH_WIDTH words
//   per character (9 at the default): three command words (is_data low)
//   then the glyph columns, with o_last_byte on the final one. Codes with no
//   stored glyph give blank columns.
//   The character is captured into the sequencer, and each word then passes
//   through the font read and output registers. Throughput: one word per
//   cycle while i_out_ready stays high, set by the single read port of the
//   font memory (one column read per word). The next character is taken in
//   the cycle the final word of the current one moves into the output
//   register, so characters run back to back with no gap.
//   Reset empties the sequencer and the output register; nothing else is
//   kept. When the receiver stalls, the output word holds and the font read
//   and sequencer pause with it.
// ----------------------------------------------------------------------------
module glyph_6x8_page_writer_top #(
    parameter int GLYPH_COUNT = 92,
    parameter int GLYPH_WIDTH = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_column,
    input  logic [7:0] i_page,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_byte_out,
    output logic       o_is_data,
    output logic       o_last_byte
);
    import gpw_pkg::*;

    localparam int ROM_DEPTH = (GLYPH_COUNT < ROM_GLYPHS) ? GLYPH_COUNT : ROM_GLYPHS;
    localparam int ROM_WIDTH = (GLYPH_WIDTH < ROM_COLS) ? GLYPH_WIDTH : ROM_COLS;

    t_gpw_rd_req rd_req;
    t_gpw_slot   slot;
    logic [7:0]  rom_data;
    logic        seq_busy;
    logic        b_take;

    logic        r_b_valid;
    t_gpw_slot   r_b_slot;

    gpw_sequencer #(
        .GLYPH_WIDTH (GLYPH_WIDTH),
        .ROM_DEPTH   (ROM_DEPTH),
        .ROM_WIDTH   (ROM_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_page      (i_page),
        .i_advance   (b_take),
        .o_busy      (seq_busy),
        .o_rd_req    (rd_req),
        .o_slot      (slot)
    );

    gpw_font_rom #(
        .DEPTH (ROM_DEPTH),
        .COLS  (ROM_WIDTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_req  (rd_req),
        .o_data (rom_data)
    );

    // Output register loads whenever it is empty or being drained
    assign b_take = !r_b_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_take) begin
            r_b_valid <= seq_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_take) begin
            r_b_slot <= slot;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_byte_out  = r_b_slot.is_data ? rom_data : r_b_slot.cmd;
    assign o_is_data   = r_b_slot.is_data;
    assign o_last_byte = r_b_slot.last;

    // The final word of a character is always a glyph column
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_byte) |-> o_is_data)
        else $error("last word flagged on a command byte");

    // Inside a character the next word follows without a bubble
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_byte) |=> o_out_valid)
        else $error("gap inside a character");

    // A new character overlaps the old one only as its final word moves into the output register
    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && seq_busy) |-> (b_take && slot.last))
        else $error("character taken while the previous one is unfinished");

    // A font read is always issued in the same cycle as an output register load
    a_read_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_req.en |-> (b_take && seq_busy))
        else $error("font read without an output register load");

endmodule

[design/gpw_font_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_font_rom
// Glyph column memory with a registered read port. A read that misses the
// stored glyphs or columns returns a blank column.
// ----------------------------------------------------------------------------
module gpw_font_rom #(
    parameter int DEPTH = 92,
    parameter int COLS  = 6
) (
    input  logic                i_clk,
    input  gpw_pkg::t_gpw_rd_req i_req,
    output logic [7:0]          o_data
);
    import gpw_pkg::*;

    localparam int GW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [7:0] rom_mem [DEPTH][COLS];
    logic [7:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_row
        for (genvar c = 0; c < COLS; c++) begin : g_col
            assign rom_mem[g][c] = FONT_ROM[g][c];
        end
    end

    // Hold the last word while the output side stalls
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_data <= i_req.hit ? rom_mem[i_req.glyph[GW-1:0]][i_req.col[CW-1:0]] : 8'h00;
        end
    end

    assign o_data = r_data;

endmodule

[design/gpw_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpw_sequencer
// Captures one character, folds the position into range and steps through
// the header bytes and glyph columns, issuing one font read per byte.
// ----------------------------------------------------------------------------
module gpw_sequencer #(
    parameter int GLYPH_WIDTH = 6,
    parameter int ROM_DEPTH   = 92,
    parameter int ROM_WIDTH   = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_char_code,
    input  logic [7:0]           i_column,
    input  logic [7:0]           i_page,
    input  logic                 i_advance,
    output logic                 o_busy,
    output gpw_pkg::t_gpw_rd_req o_rd_req,
    output gpw_pkg::t_gpw_slot   o_slot
);
    import gpw_pkg::*;

    localparam int TOTAL = HDR_BYTES + GLYPH_WIDTH;
    localparam int IDX_W = $clog2(TOTAL);

    logic                   r_busy, n_busy;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [2:0]             r_page;
    logic [6:0]             r_col;
    logic [GLYPH_IDX_W-1:0] r_glyph;
    logic                   r_glyph_hit;

    logic             col_wrap;
    logic [7:0]       page_eff;
    logic [7:0]       glyph_code;
    logic [IDX_W-1:0] dcol;
    logic [7:0]       cmd;
    logic             last_idx, is_data, col_hit, step, accept;

    always_comb begin
        col_wrap   = i_column > COL_LAST;
        page_eff   = col_wrap ? (i_page + 8'd1) : i_page;
        glyph_code = i_char_code - FONT_FIRST;

        last_idx   = r_idx == IDX_W'(TOTAL - 1);
        step       = r_busy && i_advance;
        o_in_ready = !r_busy || (step && last_idx);
        accept     = i_in_valid && o_in_ready;

        n_busy = r_busy;
        n_idx  = r_idx;
        if (accept) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (step && last_idx) begin
            n_busy = 1'b0;
        end else if (step) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page      <= (page_eff <= PAGE_LAST) ? page_eff[2:0] : 3'd0;
            r_col       <= col_wrap ? 7'd0 : i_column[6:0];
            r_glyph     <= glyph_code[GLYPH_IDX_W-1:0];
            r_glyph_hit <= glyph_code < 8'(ROM_DEPTH);
        end
    end

    always_comb begin
        case (r_idx)
            IDX_W'(IDX_PAGE_CMD): cmd = CMD_PAGE_BASE + {5'd0, r_page};
            IDX_W'(IDX_COL_HI):   cmd = CMD_COL_HIGH | {5'd0, r_col[6:4]};
            IDX_W'(IDX_COL_LO):   cmd = {1'b0, r_col} & COL_LOW_MASK;
            default:              cmd = 8'h00;
        endcase

        is_data = r_idx >= IDX_W'(HDR_BYTES);
        dcol    = r_idx - IDX_W'(HDR_BYTES);
        col_hit = 8'(dcol) < 8'(ROM_WIDTH);

        o_rd_req.en    = step;
        o_rd_req.hit   = r_glyph_hit && is_data && col_hit;
        o_rd_req.glyph = r_glyph;
        o_rd_req.col   = COL_IDX_W'(dcol);

        o_slot.cmd     = cmd;
        o_slot.is_data = is_data;
        o_slot.last    = last_idx;
    end

    assign o_busy = r_busy;

endmodule
